[hw/rtl/wav_pcm_stream_parser_macros.svh]
// ---------------------------------------------------------------------------
// WAVE parser assertion macros
// Shared concurrent assertion forms for the WAVE PCM stream parser.
// ---------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_PARSER_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPP_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wpp_pkg.sv]
// ---------------------------------------------------------------------------
// WAVE parser package
// Item types, result codes and header constants of the WAVE PCM parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpp_pkg;

    // One byte of the incoming file.
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_item_t;

    // One result of the parser.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic [1:0]         channel_count;
        logic [31:0]        rate_hz;
        logic [4:0]         bits_per_sample;
        logic [31:0]        frame_count;
        logic [2:0]         error_code;
        logic               last;
    } result_t;

    // Write strobes from the front end into the result queue.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    // Queue status seen by the front end and the output stage.
    typedef struct packed {
        logic not_empty;
        logic room;
    } q_status_t;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_TAGS      = 3'd0;
    localparam logic [2:0] ERR_FORMAT    = 3'd1;
    localparam logic [2:0] ERR_SHORT     = 3'd2;
    localparam logic [2:0] ERR_NO_DATA   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int         HEADER_BYTES = 44;
    localparam int         POS_W        = $clog2(HEADER_BYTES);
    localparam logic [7:0] PCM_BIAS     = 8'd128;

    function automatic result_t error_item(input logic [2:0] code);
        result_t item;
        item            = '0;
        item.kind       = KIND_ERROR;
        item.error_code = code;
        item.last       = 1'b1;
        return item;
    endfunction

    function automatic result_t info_item(
        input logic [1:0]  kind,
        input logic [15:0] sample,
        input logic        chan_idx,
        input logic [1:0]  chans,
        input logic [31:0] rate,
        input logic [4:0]  bits,
        input logic [31:0] frames,
        input logic        last
    );
        result_t item;
        item                 = '0;
        item.kind            = kind;
        item.sample_value    = $signed(sample);
        item.channel_index   = chan_idx;
        item.channel_count   = chans;
        item.rate_hz         = rate;
        item.bits_per_sample = bits;
        item.frame_count     = frames;
        item.last            = last;
        return item;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wpp_stream_if.sv]
// ---------------------------------------------------------------------------
// WAVE parser stream channel
// Valid/ready channel that carries one payload item per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wpp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/wpp_front.sv]
// ---------------------------------------------------------------------------
// WAVE parser front end
// Takes file bytes, tracks the header and chunk walk, and writes results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wav_pcm_stream_parser_macros.svh"

module wpp_front (
    input  logic                clk,
    input  logic                rst_n,
    wpp_stream_if.sink          byte_ch,
    input  wpp_pkg::q_status_t  q_status,
    output wpp_pkg::push_t      push,
    output wpp_pkg::result_t    res_first,
    output wpp_pkg::result_t    res_second
);

    localparam int PW = wpp_pkg::POS_W;

    localparam logic [PW-1:0] P_WAVE     = PW'(8);
    localparam logic [PW-1:0] P_WALK     = PW'(12);
    localparam logic [PW-1:0] P_FMT_LO   = PW'(20);
    localparam logic [PW-1:0] P_FMT_HI   = PW'(21);
    localparam logic [PW-1:0] P_CH_LO    = PW'(22);
    localparam logic [PW-1:0] P_CH_HI    = PW'(23);
    localparam logic [PW-1:0] P_RATE     = PW'(24);
    localparam logic [PW-1:0] P_RATE_END = PW'(28);
    localparam logic [PW-1:0] P_BITS_LO  = PW'(34);
    localparam logic [PW-1:0] P_BITS_HI  = PW'(35);
    localparam logic [PW-1:0] P_HDR_LAST = PW'(wpp_pkg::HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SKIP,
        PH_DATA,
        PH_WAIT,
        PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [2:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      skip_reg, skip_next;
    logic [31:0]      data_left_reg, data_left_next;
    logic [31:0]      rate_reg, rate_next;
    logic [1:0]       chan_reg, chan_next;
    logic [4:0]       bits_reg, bits_next;
    logic [7:0]       hold_reg, hold_next;
    logic             cur_ch_reg, cur_ch_next;

    logic             accept;
    logic [1:0]       n_res;
    wpp_pkg::result_t res_a, res_b;

    assign byte_ch.ready = q_status.room;
    assign accept        = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        logic [7:0]       b;
        logic             eof;
        logic [PW-1:0]    p;
        phase_t           ph_mid;
        logic [15:0]      word;
        logic [1:0]       shift;
        logic [31:0]      frames;
        logic [31:0]      skip_len;
        logic [15:0]      sample;
        wpp_pkg::result_t item;

        b      = byte_ch.payload.file_byte;
        eof    = byte_ch.payload.end_of_file;
        p      = pos_reg;
        word   = {b, hold_reg};
        shift  = 2'd0;
        frames = 32'd0;
        skip_len = 32'd0;
        sample = 16'd0;
        item   = '0;

        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        skip_next      = skip_reg;
        data_left_next = data_left_reg;
        rate_next      = rate_reg;
        chan_next      = chan_reg;
        bits_next      = bits_reg;
        hold_next      = hold_reg;
        cur_ch_next    = cur_ch_reg;

        n_res = 2'd0;
        res_a = '0;
        res_b = '0;

        // Header fields at fixed offsets; the first fault ends the file.
        if (phase_reg != PH_DONE)
        begin
            if (p < PW'(4))
            begin
                if (b != wpp_pkg::TAG_RIFF[{~p[1:0], 3'b000} +: 8])
                begin
                    item       = wpp_pkg::error_item(wpp_pkg::ERR_TAGS);
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    res_a      = item;
                end
            end
            else if (p >= P_WAVE && p < P_WALK)
            begin
                if (b != wpp_pkg::TAG_WAVE[{~p[1:0], 3'b000} +: 8])
                begin
                    item       = wpp_pkg::error_item(wpp_pkg::ERR_TAGS);
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    res_a      = item;
                end
            end
            else if (p == P_FMT_LO || p == P_CH_LO || p == P_BITS_LO)
            begin
                hold_next = b;
            end
            else if (p == P_FMT_HI)
            begin
                if (word != 16'd1)
                begin
                    item       = wpp_pkg::error_item(wpp_pkg::ERR_FORMAT);
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    res_a      = item;
                end
            end
            else if (p == P_CH_HI)
            begin
                if (word != 16'd1 && word != 16'd2)
                begin
                    item       = wpp_pkg::error_item(wpp_pkg::ERR_FORMAT);
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    res_a      = item;
                end
                else
                begin
                    chan_next = word[1:0];
                end
            end
            else if (p >= P_RATE && p < P_RATE_END)
            begin
                rate_next[{p[1:0], 3'b000} +: 8] = b;
            end
            else if (p == P_BITS_HI)
            begin
                if (word != 16'd8 && word != 16'd16)
                begin
                    item       = wpp_pkg::error_item(wpp_pkg::ERR_FORMAT);
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    res_a      = item;
                end
                else
                begin
                    bits_next = word[4:0];
                end
            end
        end

        ph_mid = phase_next;

        if (ph_mid == PH_HDR && p >= P_WALK)
        begin
            // Chunk header: four tag bytes, then a little-endian size.
            if (hdr_cnt_reg < 3'd4)
            begin
                tag_next = {tag_reg[23:0], b};
            end
            else
            begin
                size_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = b;
            end
            hdr_cnt_next = hdr_cnt_reg + 3'd1;
            if (hdr_cnt_reg == 3'd7)
            begin
                hdr_cnt_next = 3'd0;
                if (tag_next == wpp_pkg::TAG_DATA)
                begin
                    if (p < P_BITS_HI)
                    begin
                        item       = wpp_pkg::error_item(wpp_pkg::ERR_SHORT);
                        phase_next = PH_DONE;
                        res_a      = item;
                        n_res      = 2'd1;
                    end
                    else
                    begin
                        // Frame size is 1, 2 or 4 bytes, so the frame count is a shift.
                        shift  = {1'b0, chan_next == 2'd2} + {1'b0, bits_next == 5'd16};
                        frames = size_next >> shift;
                        if (frames == 32'd0)
                        begin
                            item       = wpp_pkg::error_item(wpp_pkg::ERR_NO_DATA);
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            item = wpp_pkg::info_item(wpp_pkg::KIND_FORMAT, 16'd0, 1'b0,
                                                      chan_next, rate_next, bits_next,
                                                      frames, 1'b0);
                            data_left_next = frames << shift;
                            cur_ch_next    = 1'b0;
                            phase_next     = PH_DATA;
                        end
                        res_a = item;
                        n_res = 2'd1;
                    end
                end
                else
                begin
                    skip_len   = (size_next + 32'd1) & ~32'd1;
                    skip_next  = skip_len;
                    phase_next = (skip_len != 32'd0) ? PH_SKIP : PH_HDR;
                end
                tag_next  = 32'd0;
                size_next = 32'd0;
            end
        end
        else if (ph_mid == PH_SKIP)
        begin
            skip_next = skip_reg - 32'd1;
            if (skip_reg == 32'd1)
            begin
                phase_next = PH_HDR;
            end
        end
        else if (ph_mid == PH_DATA)
        begin
            data_left_next = data_left_reg - 32'd1;
            if (bits_reg == 5'd8 || data_left_reg[0])
            begin
                sample = (bits_reg == 5'd8) ? {b ^ wpp_pkg::PCM_BIAS, 8'd0} : word;
                item   = wpp_pkg::info_item(wpp_pkg::KIND_SAMPLE, sample, cur_ch_reg,
                                            chan_next, rate_next, bits_next,
                                            32'd0, 1'b0);
                res_a  = item;
                n_res  = 2'd1;
                cur_ch_next = (chan_reg == 2'd2) ? ~cur_ch_reg : 1'b0;
            end
            else
            begin
                hold_next = b;
            end
            if (data_left_reg == 32'd1)
            begin
                phase_next = PH_WAIT;
            end
        end

        // Done waits until the whole 44-byte header span has gone by.
        if (phase_next == PH_WAIT && p >= P_HDR_LAST)
        begin
            item = wpp_pkg::info_item(wpp_pkg::KIND_DONE, 16'd0, 1'b0, chan_next,
                                      rate_next, bits_next, 32'd0, 1'b1);
            if (n_res == 2'd0)
            begin
                res_a = item;
            end
            else
            begin
                res_b = item;
            end
            n_res      = n_res + 2'd1;
            phase_next = PH_DONE;
        end

        if (eof && phase_next != PH_DONE)
        begin
            if (p < P_HDR_LAST)
            begin
                item = wpp_pkg::error_item(wpp_pkg::ERR_SHORT);
            end
            else if (phase_next == PH_DATA)
            begin
                item = wpp_pkg::error_item(wpp_pkg::ERR_TRUNCATED);
            end
            else
            begin
                item = wpp_pkg::error_item(wpp_pkg::ERR_NO_DATA);
            end
            if (n_res == 2'd0)
            begin
                res_a = item;
            end
            else
            begin
                res_b = item;
            end
            n_res      = n_res + 2'd1;
            phase_next = PH_DONE;
        end

        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + PW'(1);

        // The byte after an end of file starts a new file.
        if (eof)
        begin
            phase_next     = PH_HDR;
            pos_next       = '0;
            hdr_cnt_next   = 3'd0;
            tag_next       = 32'd0;
            size_next      = 32'd0;
            skip_next      = 32'd0;
            data_left_next = 32'd0;
            rate_next      = 32'd0;
            chan_next      = 2'd0;
            bits_next      = 5'd0;
            hold_next      = 8'd0;
            cur_ch_next    = 1'b0;
        end
    end

    assign push.first  = accept && (n_res != 2'd0);
    assign push.second = accept && (n_res == 2'd2);
    assign res_first   = res_a;
    assign res_second  = res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            pos_reg       <= '0;
            hdr_cnt_reg   <= 3'd0;
            tag_reg       <= 32'd0;
            size_reg      <= 32'd0;
            skip_reg      <= 32'd0;
            data_left_reg <= 32'd0;
            rate_reg      <= 32'd0;
            chan_reg      <= 2'd0;
            bits_reg      <= 5'd0;
            hold_reg      <= 8'd0;
            cur_ch_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            tag_reg       <= tag_next;
            size_reg      <= size_next;
            skip_reg      <= skip_next;
            data_left_reg <= data_left_next;
            rate_reg      <= rate_next;
            chan_reg      <= chan_next;
            bits_reg      <= bits_next;
            hold_reg      <= hold_next;
            cur_ch_reg    <= cur_ch_next;
        end
    end

    `WPP_ASSERT_NEXT(a_eof_restarts, clk, rst_n, accept && byte_ch.payload.end_of_file, pos_reg == '0 && phase_reg == PH_HDR, "end of file did not restart the parser")
    `WPP_ASSERT_SAME(a_second_needs_first, clk, rst_n, push.second, push.first, "second result written without a first")
    `WPP_ASSERT_SAME(a_finished_silent, clk, rst_n, accept && phase_reg == PH_DONE, !push.first, "result produced after the file finished")

endmodule

`default_nettype wire

[hw/rtl/wpp_queue.sv]
// ---------------------------------------------------------------------------
// WAVE parser result queue
// Small FIFO that takes up to two results a cycle and gives one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wav_pcm_stream_parser_macros.svh"

module wpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wpp_pkg::push_t      push,
    input  wpp_pkg::result_t    wr_first,
    input  wpp_pkg::result_t    wr_second,
    input  logic                pop,
    output wpp_pkg::q_status_t  status,
    output wpp_pkg::result_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wpp_pkg::result_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_alt;

    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign wr_alt = step(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.second)
        begin
            wr_ptr_next = step(wr_alt);
        end
        else if (push.first)
        begin
            wr_ptr_next = wr_alt;
        end
        rd_ptr_next = pop ? step(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            store_reg[wr_ptr_reg] <= wr_first;
        end
        if (push.second)
        begin
            store_reg[wr_alt] <= wr_second;
        end
    end

    assign status.not_empty = (count_reg != '0);
    assign status.room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head             = store_reg[rd_ptr_reg];

    `WPP_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "result queue overfilled")
    `WPP_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, count_reg != '0, "result queue read while empty")

endmodule

`default_nettype wire

[hw/rtl/wpp_back.sv]
// ---------------------------------------------------------------------------
// WAVE parser output stage
// Registered output that drains the result queue onto the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wpp_pkg::q_status_t  q_status,
    input  wpp_pkg::result_t    head,
    output logic                pop,
    wpp_stream_if.source        result_ch
);

    logic             valid_reg, valid_next;
    wpp_pkg::result_t item_reg;

    // Load from a non-empty queue when the register is empty or being taken.
    assign pop        = q_status.not_empty && (!valid_reg || result_ch.ready);
    assign valid_next = pop || (valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    assign result_ch.valid   = valid_reg;
    assign result_ch.payload = item_reg;

endmodule

`default_nettype wire

[hw/rtl/wav_pcm_stream_parser.sv]
// ---------------------------------------------------------------------------
// WAVE PCM stream parser
// Parses a RIFF/WAVE file byte by byte and emits format, sample and status
// results.
// ---------------------------------------------------------------------------
//
//   Channel         Direction  Payload            One request carries
//   file_stream     sink       byte_item_t        one file byte and its end mark
//   result_stream   source     result_t           one format, sample, done or
//                                                 error result
//
// One byte is taken per cycle when the result queue has room for two results.
// A result goes into the queue as its byte is taken, then through the output
// register onto result_stream. A byte that causes two results slows only the
// output side; the queue absorbs the second one while bytes keep arriving.
// Reset clears the parser state, the queue and the output register at once.
// A stall on result_stream fills the queue; file_stream then stalls until
// there is room for two results again.
//
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wav_pcm_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    wpp_stream_if.sink    file_stream,
    wpp_stream_if.source  result_stream
);

    // Front end to queue: write strobes and the two result slots.
    wpp_pkg::push_t     push;
    wpp_pkg::result_t   res_first;
    wpp_pkg::result_t   res_second;

    // Queue to front end and output stage.
    wpp_pkg::q_status_t q_status;
    wpp_pkg::result_t   head;
    logic               pop;

    // The front end walks the header and chunk list and turns every byte into
    // zero, one or two results; it only takes a byte when both can be queued.
    wpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (file_stream),
        .q_status   (q_status),
        .push       (push),
        .res_first  (res_first),
        .res_second (res_second)
    );

    // The queue lets the front end run on while the output side is stalled.
    wpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_first  (res_first),
        .wr_second (res_second),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    // The output stage holds one result in a register for the consumer.
    wpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .result_ch (result_stream)
    );

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAVE PCM stream parser testbench
// Feeds whole and damaged RIFF/WAVE files into the parser one byte per
// request. A behavioural copy of the parser in this file predicts every
// result, and each result that leaves the block is compared field by field
// with the oldest prediction. Both channels idle at random.
// ---------------------------------------------------------------------------

module tb_top;

    import wpp_pkg::*;

    // Chunk tags that the parser does not look for; they only get skipped.
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_LIST = 32'h4c49_5354;
    localparam logic [31:0] TAG_JUNK = 32'h6a75_6e6b;
    localparam logic [15:0] PCM_CODE = 16'd1;

    // Phases of the behavioural parser.
    typedef enum logic [2:0] {
        ST_CHUNK_HDR,
        ST_SKIP,
        ST_PAYLOAD,
        ST_WAIT_HDR,
        ST_FINISHED
    } parse_stage_e;

    logic clk;
    logic rst_n;

    wpp_stream_if #(.payload_t(byte_item_t)) file_if ();
    wpp_stream_if #(.payload_t(result_t))    result_if ();

    wav_pcm_stream_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_stream   (file_if),
        .result_stream (result_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // -----------------------------------------------------------------------
    // Shared state of the stimulus, the prediction and the checking.
    // -----------------------------------------------------------------------

    result_t     expected_results[$];
    logic [7:0]  wave_bytes[$];
    int          mismatches        = 0;
    int          bytes_sent        = 0;
    // Odds of one in N that a gap or a stall starts; zero means none at all.
    int          source_gap_odds   = 0;
    int          sink_stall_odds   = 0;
    // A long hold-off on the result side, picked up by the sink process.
    int          sink_hold_cycles  = 0;

    // Behavioural parser state; everything returns to this after the last
    // byte of each file.
    logic [31:0]  offset;
    parse_stage_e stage;
    logic [31:0]  size_acc;
    logic [31:0]  tag_acc;
    logic [31:0]  hdr_count;
    logic [31:0]  payload_left;
    logic [31:0]  rate_acc;
    logic [15:0]  chans_acc;
    logic [15:0]  bits_acc;
    logic [7:0]   held_low;
    logic         next_chan;

    task automatic clear_parser();
        offset       = '0;
        stage        = ST_CHUNK_HDR;
        size_acc     = '0;
        tag_acc      = '0;
        hdr_count    = '0;
        payload_left = '0;
        rate_acc     = '0;
        chans_acc    = '0;
        bits_acc     = '0;
        held_low     = '0;
        next_chan    = 1'b0;
    endtask

    // Builds one result. The header fields gathered so far ride along on
    // every result except an error, which carries them as zero.
    function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] sample,
                                            input logic chan, input logic [31:0] frames,
                                            input logic [2:0] code);
        result_t r;
        r               = '0;
        r.kind          = kind;
        r.sample_value  = sample;
        r.channel_index = chan;
        r.frame_count   = frames;
        r.error_code    = code;
        r.last          = (kind == KIND_DONE) || (kind == KIND_ERROR);
        if (kind != KIND_ERROR)
        begin
            r.channel_count   = chans_acc[1:0];
            r.rate_hz         = rate_acc;
            r.bits_per_sample = bits_acc[4:0];
        end
        return r;
    endfunction

    task automatic report_fault(input logic [2:0] code);
        expected_results.push_back(make_result(KIND_ERROR, 16'd0, 1'b0, 32'd0, code));
        stage = ST_FINISHED;
    endtask

    // Advances the behavioural parser by one accepted byte and queues the
    // results that this byte must cause, in order.
    task automatic parse_wave_byte(input logic [7:0] value, input logic eof);
        logic [31:0] p;
        logic [15:0] word;
        logic [31:0] frame_bytes;
        logic [31:0] frames;
        logic [15:0] sample;
        logic        have;
        p    = offset;
        word = {value, held_low};

        // Header fields sit at fixed offsets, whatever the chunk walk is doing.
        if (stage != ST_FINISHED)
        begin
            if (p < 4)
            begin
                if (value != TAG_RIFF[8 * (3 - int'(p[1:0])) +: 8])
                    report_fault(ERR_TAGS);
            end
            else if (p >= 8 && p < 12)
            begin
                if (value != TAG_WAVE[8 * (3 - int'(p[1:0])) +: 8])
                    report_fault(ERR_TAGS);
            end
            else if (p == 20 || p == 22 || p == 34)
                held_low = value;
            else if (p == 21)
            begin
                if (word != PCM_CODE)
                    report_fault(ERR_FORMAT);
            end
            else if (p == 23)
            begin
                if (word < 1 || word > 2)
                    report_fault(ERR_FORMAT);
                else
                    chans_acc |= word;
            end
            else if (p >= 24 && p < 28)
                rate_acc |= 32'(value) << (8 * (p - 24));
            else if (p == 35)
            begin
                if (word != 16'd8 && word != 16'd16)
                    report_fault(ERR_FORMAT);
                else
                    bits_acc |= word;
            end
        end

        // Chunk walk from offset 12: an 8-byte header, then a skip or the data.
        if (stage == ST_CHUNK_HDR && p >= 12)
        begin
            if (hdr_count < 4)
                tag_acc = {tag_acc[23:0], value};
            else
                size_acc |= 32'(value) << (8 * hdr_count[1:0]);
            hdr_count++;
            if (hdr_count >= 8)
            begin
                hdr_count = '0;
                if (tag_acc == TAG_DATA)
                begin
                    if (p < 35)
                        report_fault(ERR_SHORT);
                    else
                    begin
                        frame_bytes = 32'(chans_acc) * 32'(bits_acc / 16'd8);
                        frames      = (frame_bytes != 0) ? size_acc / frame_bytes : 32'd0;
                        if (frames == 0)
                            report_fault(ERR_NO_DATA);
                        else
                        begin
                            expected_results.push_back(
                                make_result(KIND_FORMAT, 16'd0, 1'b0, frames, ERR_TAGS));
                            payload_left = frames * frame_bytes;
                            next_chan    = 1'b0;
                            stage        = ST_PAYLOAD;
                        end
                    end
                end
                else
                begin
                    // The padded size wraps to zero for the largest size.
                    hdr_count = (size_acc + 32'd1) & ~32'd1;
                    stage     = (hdr_count != 0) ? ST_SKIP : ST_CHUNK_HDR;
                end
                tag_acc  = '0;
                size_acc = '0;
            end
        end
        else if (stage == ST_SKIP)
        begin
            hdr_count--;
            if (hdr_count == 0)
                stage = ST_CHUNK_HDR;
        end
        else if (stage == ST_PAYLOAD)
        begin
            have   = 1'b0;
            sample = '0;
            if (bits_acc == 16'd8)
            begin
                sample = {value ^ PCM_BIAS, 8'h00};
                have   = 1'b1;
            end
            else if (!payload_left[0])
                held_low = value;
            else
            begin
                sample = {value, held_low};
                have   = 1'b1;
            end
            payload_left--;
            if (have)
            begin
                expected_results.push_back(
                    make_result(KIND_SAMPLE, sample, next_chan, 32'd0, ERR_TAGS));
                next_chan = (chans_acc == 16'd2) ? ~next_chan : 1'b0;
            end
            if (payload_left == 0)
                stage = ST_WAIT_HDR;
        end

        // Done is held back until the whole 44-byte header has gone by.
        if (stage == ST_WAIT_HDR && p >= HEADER_BYTES - 1)
        begin
            expected_results.push_back(make_result(KIND_DONE, 16'd0, 1'b0, 32'd0, ERR_TAGS));
            stage = ST_FINISHED;
        end

        if (eof && stage != ST_FINISHED)
        begin
            if (p < HEADER_BYTES - 1)
                report_fault(ERR_SHORT);
            else if (stage == ST_PAYLOAD)
                report_fault(ERR_TRUNCATED);
            else
                report_fault(ERR_NO_DATA);
        end

        if (offset != '1)
            offset++;
        if (eof)
            clear_parser();
    endtask

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("kind: expected nothing, actual %0d", got.kind);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("sample_value", want.sample_value, got.sample_value);
        compare_field("channel_index", want.channel_index, got.channel_index);
        compare_field("channel_count", want.channel_count, got.channel_count);
        compare_field("rate_hz", want.rate_hz, got.rate_hz);
        compare_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
        compare_field("frame_count", want.frame_count, got.frame_count);
        compare_field("error_code", want.error_code, got.error_code);
        compare_field("last", want.last, got.last);
    endtask

    // Both channels are sampled at the clock edge, before anything that the
    // edge schedules has landed, so each request is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (file_if.valid && file_if.ready)
                parse_wave_byte(file_if.payload.file_byte, file_if.payload.end_of_file);
            if (result_if.valid && result_if.ready)
                check_result(result_if.payload);
        end
    end

    // Result side: random stalls, or one long hold-off when a test asks for
    // it. The hold-off is counted here so that the sender keeps offering bytes.
    initial
    begin : result_sink
        int stall;
        result_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (sink_hold_cycles != 0)
            begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // File building and sending.
    // -----------------------------------------------------------------------

    task automatic push_le(input logic [31:0] value, input int count);
        for (int i = 0; i < count; i++)
            wave_bytes.push_back(value[8 * i +: 8]);
    endtask

    task automatic push_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            wave_bytes.push_back(tag[8 * i +: 8]);
    endtask

    // RIFF and WAVE tags plus a 16-byte fmt chunk: exactly 36 bytes, so that
    // the format fields land at the offsets the parser reads.
    task automatic start_wave(input logic [15:0] code, input logic [15:0] chans,
                              input logic [31:0] rate, input logic [15:0] bits);
        wave_bytes.delete();
        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        push_tag(TAG_WAVE);
        push_tag(TAG_FMT);
        push_le(32'd16, 4);
        push_le(code, 2);
        push_le(chans, 2);
        push_le(rate, 4);
        push_le(rate * chans * bits / 8, 4);
        push_le(chans * bits / 8, 2);
        push_le(bits, 2);
    endtask

    // A chunk header with the given size, then body_len random bytes.
    task automatic push_chunk(input logic [31:0] tag, input logic [31:0] size,
                              input int body_len);
        push_tag(tag);
        push_le(size, 4);
        repeat (body_len) push_le($urandom, 1);
    endtask

    // A plain, valid file with a short data chunk, for damaging in place.
    task automatic build_basic_wave(input logic [15:0] code, input logic [15:0] chans,
                                    input logic [15:0] bits);
        start_wave(code, chans, $urandom, bits);
        push_chunk(TAG_DATA, 32'd4, 4);
    endtask

    // Sends one byte as one request, after an optional random gap.
    task automatic send_byte(input logic [7:0] value, input logic eof);
        byte_item_t item;
        item.file_byte   = value;
        item.end_of_file = eof;
        if (source_gap_odds != 0 && $urandom_range(1, source_gap_odds) == 1)
        begin
            file_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        file_if.valid   <= 1'b1;
        file_if.payload <= item;
        @(posedge clk);
        while (!file_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the built file with the end mark on its last byte. The next
    // request follows straight on, so valid is only dropped by a gap or at
    // the end of the run.
    task automatic send_wave();
        for (int i = 0; i < wave_bytes.size(); i++)
            send_byte(wave_bytes[i], i == wave_bytes.size() - 1);
    endtask

    // -----------------------------------------------------------------------
    // Tests.
    // -----------------------------------------------------------------------

    // Good files: stereo 16-bit behind an odd-sized chunk with a tail byte,
    // mono 8-bit at the sample extremes, and a chunk of the largest size that
    // wraps to a skip of nothing.
    task automatic test_good_files();
        start_wave(PCM_CODE, 16'd2, 32'd44100, 16'd16);
        push_chunk(TAG_LIST, 32'd3, 4);
        push_tag(TAG_DATA);
        push_le(32'd9, 4);
        push_le(32'h8000_0000, 4);
        push_le(32'hffff_7fff, 4);
        push_le(32'h5a, 1);
        push_chunk(TAG_LIST, 32'd0, 0);
        send_wave();

        start_wave(PCM_CODE, 16'd1, 32'hffff_ffff, 16'd8);
        push_tag(TAG_DATA);
        push_le(32'd4, 4);
        push_le(32'h7f80_ff00, 4);
        send_wave();

        start_wave(PCM_CODE, 16'd2, 32'd8000, 16'd8);
        push_chunk(TAG_JUNK, 32'hffff_ffff, 0);
        push_chunk(TAG_DATA, 32'd2, 2);
        send_wave();
    endtask

    // Each fixed-offset check, one damaged byte per file. The file ends on
    // the byte after the damage, by which point the fault has been seen.
    task automatic test_header_faults();
        int          spot[12]  = '{0, 3, 8, 11, 20, 21, 22, 22, 23, 34, 34, 35};
        logic [7:0]  patch[12] = '{8'h00, 8'h47, 8'hd7, 8'h44, 8'h03, 8'h01,
                                   8'h00, 8'h03, 8'h02, 8'h18, 8'h00, 8'h08};
        for (int i = 0; i < 12; i++)
        begin
            build_basic_wave(PCM_CODE, 16'd1, 16'd16);
            wave_bytes[spot[i]] = patch[i];
            wave_bytes = wave_bytes[0:spot[i] + 1];
            send_wave();
        end
    endtask

    // Data placed too early, empty data, short files, truncated payloads and
    // files that never reach a data chunk.
    task automatic test_data_faults();
        // Data chunk straight after the WAVE tag.
        wave_bytes.delete();
        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        push_tag(TAG_WAVE);
        push_chunk(TAG_DATA, 32'd4, 4);
        send_wave();

        // Data sizes that hold no whole frame.
        start_wave(PCM_CODE, 16'd2, $urandom, 16'd16);
        push_chunk(TAG_DATA, 32'd3, 3);
        send_wave();
        start_wave(PCM_CODE, 16'd1, $urandom, 16'd8);
        push_chunk(TAG_DATA, 32'd0, 0);
        send_wave();

        // An 8-byte fmt chunk puts the data header over the bits field, so
        // samples flow before byte 43 and the early end is still a short header.
        wave_bytes.delete();
        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        push_tag(TAG_WAVE);
        push_tag(TAG_FMT);
        push_le(32'd8, 4);
        push_le(PCM_CODE, 2);
        push_le(32'd1, 2);
        push_le($urandom, 4);
        push_chunk(TAG_DATA, 32'h0008_0002, 3);
        send_wave();

        // Plain short header, and a lone first byte.
        build_basic_wave(PCM_CODE, 16'd1, 16'd8);
        wave_bytes = wave_bytes[0:19];
        send_wave();
        wave_bytes.delete();
        push_tag(TAG_RIFF);
        wave_bytes = wave_bytes[0:0];
        send_wave();

        // End on the data header itself: format and truncation on one byte.
        build_basic_wave(PCM_CODE, 16'd2, 16'd16);
        wave_bytes = wave_bytes[0:43];
        send_wave();

        // Largest data size, cut off after an odd number of payload bytes.
        start_wave(PCM_CODE, 16'd1, $urandom, 16'd16);
        push_chunk(TAG_DATA, 32'hffff_ffff, 5);
        send_wave();

        // No data chunk: the file ends between chunks, then inside a skip.
        start_wave(PCM_CODE, 16'd1, $urandom, 16'd16);
        push_chunk(TAG_LIST, 32'd6, 6);
        send_wave();
        start_wave(PCM_CODE, 16'd2, $urandom, 16'd8);
        push_chunk(TAG_LIST, 32'd20, 6);
        send_wave();
    endtask

    // The result side holds off for a long stretch while a long file keeps
    // coming, so the block's queue fills and the file side must stall.
    task automatic test_input_stall();
        source_gap_odds  = 0;
        sink_stall_odds  = 0;
        sink_hold_cycles = 300;
        start_wave(PCM_CODE, 16'd2, 32'd48000, 16'd16);
        push_chunk(TAG_DATA, 32'd96, 96);
        send_wave();
    endtask

    // Random files until byte_budget more bytes have gone in. Most are well
    // formed with random content; a share are damaged, cut short or noise.
    task automatic test_random_files(input int byte_budget, input bit with_idling);
        int stop_at;
        int len;
        int chunk_size;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] code;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            // Idling changes per file, so some files run with none at all.
            source_gap_odds = with_idling ? 3 * $urandom_range(0, 3) : 0;
            sink_stall_odds = with_idling ? 3 * $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 9) == 0)
            begin
                wave_bytes.delete();
                push_le($urandom, 4);
                push_le($urandom, 4);
                push_le($urandom, 4);
                len = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 1)
                    wave_bytes[0] = TAG_RIFF[31:24];
                wave_bytes = wave_bytes[0:len - 1];
            end
            else
            begin
                chans = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 3))
                                                     : 16'($urandom_range(1, 2));
                bits  = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 31))
                                                     : 16'(8 * $urandom_range(1, 2));
                code  = ($urandom_range(0, 15) == 0) ? 16'($urandom) : PCM_CODE;
                start_wave(code, chans, $urandom, bits);
                repeat ($urandom_range(0, 2))
                begin
                    chunk_size = $urandom_range(0, 7);
                    push_chunk(($urandom_range(0, 3) == 0) ? $urandom : TAG_LIST,
                               chunk_size, (chunk_size + 1) & ~1);
                end
                len = $urandom_range(0, 24);
                push_chunk(TAG_DATA, len, len);
                repeat ($urandom_range(0, 3)) push_le($urandom, 1);
                if ($urandom_range(0, 4) == 0)
                    wave_bytes[$urandom_range(0, wave_bytes.size() - 1)] = 8'($urandom);
                if ($urandom_range(0, 4) == 0)
                    wave_bytes = wave_bytes[0:$urandom_range(0, wave_bytes.size() - 1)];
            end
            send_wave();
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence of the run.
    // -----------------------------------------------------------------------

    initial
    begin
        clear_parser();
        rst_n           = 1'b0;
        file_if.valid   = 1'b0;
        file_if.payload = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        source_gap_odds = 4;
        sink_stall_odds = 4;
        test_good_files();
        test_header_faults();
        test_data_faults();
        test_input_stall();
        test_random_files(120, 1'b1);
        // The last stretch runs flat out on both sides.
        test_random_files(60, 1'b0);
        file_if.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung request on either channel.
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
